// ===== rtl/scli_pkg.sv =====
// shared types and status codes for the sorted curve interpolator
`timescale 1ns / 1ps
package scli_pkg;
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_UPDATED = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_EMPTY   = 3'd3;
    localparam logic [2:0] ST_SAT     = 3'd4;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_EVAL   = 1'b1;

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_SRCH   = 13'b0000000000010,
        S_SWAIT  = 13'b0000000000100,
        S_DECIDE = 13'b0000000001000,
        S_SHIFT  = 13'b0000000010000,
        S_SHWR   = 13'b0000000100000,
        S_RD0    = 13'b0000001000000,
        S_RD1    = 13'b0000010000000,
        S_PREP   = 13'b0000100000000,
        S_MUL    = 13'b0001000000000,
        S_DIV    = 13'b0010000000000,
        S_FIN    = 13'b0100000000000,
        S_DONE   = 13'b1000000000000
    } t_state;
endpackage

// ===== rtl/sorted_curve_linear_interpolator_unit.sv =====
// top level of the sorted curve table with linear interpolation
// the search takes at most clog2(MAX_POINTS + 1) halving steps; inserts then shift entries up one by one,
//   and evaluation multiplies by shift-add and divides by restoring division
// one item at a time: start is taken only while idle, and busy drops in the strobe cycle;
//   each search step and each shift step is a read state followed by a compare or write state
// reset clears the point count and sequencer, not the table; receiver cannot stall (one-cycle strobe)
`timescale 1ns / 1ps
module sorted_curve_linear_interpolator_unit import scli_pkg::*; #(
    parameter int MAX_POINTS = 64,
    parameter int VALUE_BITS = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_action,
    input  logic signed [VALUE_BITS-1:0] i_x_value,
    input  logic signed [VALUE_BITS-1:0] i_y_value,
    output logic                         o_valid,
    output logic signed [VALUE_BITS-1:0] o_y_result,
    output logic [2:0]                   o_status,
    output logic [6:0]                   o_point_total
);
    // fraction bits cancel in the slope ratio, so FRAC_BITS sets no logic here
    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int VB = VALUE_BITS;
    localparam int DW = VB + 1;      // differences
    localparam int PW = 2 * DW;      // product
    localparam int CNTW = $clog2(PW + 1);

    // table memories, one read port, one write port
    logic [VB-1:0] r_xmem [MAX_POINTS];
    logic [VB-1:0] r_ymem [MAX_POINTS];
    logic [AW-1:0] rd_addr;
    logic [VB-1:0] r_rdx, r_rdy;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [VB-1:0] wr_x, wr_y;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_xmem[wr_addr] <= wr_x;
            r_ymem[wr_addr] <= wr_y;
        end
        r_rdx <= r_xmem[rd_addr];
        r_rdy <= r_ymem[rd_addr];
    end

    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic          r_act;
    logic signed [VB-1:0] r_x, r_y;
    logic [CW-1:0] r_lo, r_hi, r_ptr;
    logic [CW-1:0] n_lo, n_hi, n_ptr;
    logic signed [VB-1:0] r_x0, r_y0, n_x0, n_y0;
    logic [PW-1:0] r_acc, n_acc;     // multiplier / product / dividend
    logic [PW-1:0] r_mc, n_mc;
    logic [DW-1:0] r_dx, n_dx;
    logic [DW:0]   r_rem, n_rem;
    logic          r_neg, n_neg;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic signed [VB-1:0] r_res, n_res;
    logic [2:0]    r_st, n_st;
    logic          r_valid, n_valid;

    logic [CW-1:0] mid;
    logic signed [DW-1:0] dy_s, dq_s, dx_s;
    logic [DW:0]   trial;
    logic [PW:0]   mul_sum;
    logic signed [PW+1:0] sum_w;
    localparam logic signed [PW+1:0] VMAX = (PW+2)'((64'sd1 <<< (VB-1)) - 1);
    localparam logic signed [PW+1:0] VMIN = -(PW+2)'(64'sd1 <<< (VB-1));

    assign mid = CW'((({1'b0, r_lo} + {1'b0, r_hi}) >> 1));

    always_comb begin
        n_state = r_state; n_count = r_count;
        n_lo = r_lo; n_hi = r_hi; n_ptr = r_ptr;
        n_x0 = r_x0; n_y0 = r_y0; n_acc = r_acc; n_mc = r_mc; n_dx = r_dx;
        n_rem = r_rem; n_neg = r_neg; n_cnt = r_cnt; n_res = r_res; n_st = r_st;
        n_valid = 1'b0;
        rd_addr = mid[AW-1:0];
        wr_en = 1'b0; wr_addr = r_ptr[AW-1:0]; wr_x = r_x; wr_y = r_y;
        dy_s = $signed({r_rdy[VB-1], r_rdy}) - $signed({r_y0[VB-1], r_y0});
        dx_s = $signed({r_rdx[VB-1], r_rdx}) - $signed({r_x0[VB-1], r_x0});
        dq_s = $signed({r_x[VB-1], r_x}) - $signed({r_x0[VB-1], r_x0});
        trial = {r_rem[DW-1:0], r_acc[PW-1]} - {1'b0, r_dx};
        mul_sum = {1'b0, r_acc} + ({1'b0, r_mc} << DW);
        sum_w = r_neg ? (PW+2)'(r_y0) - $signed({2'b00, r_acc})
                      : (PW+2)'(r_y0) + $signed({2'b00, r_acc});
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_lo = '0; n_hi = r_count; n_res = '0; n_st = ST_OK;
                    n_state = S_SRCH;
                end
            end
            S_SRCH: begin
                // one halving step: read mid, compare next cycle
                if (r_lo < r_hi) n_state = S_SWAIT;
                else n_state = S_DECIDE;
            end
            S_SWAIT: begin
                if (r_act == ACT_INSERT ? ($signed(r_rdx) < r_x) : ($signed(r_rdx) <= r_x))
                    n_lo = mid + 1'b1;
                else
                    n_hi = mid;
                n_state = S_SRCH;
            end
            S_DECIDE: begin
                if (r_act == ACT_INSERT) begin
                    // pos == lo; exact-match check needs the read of lo
                    n_state = S_RD0;
                end else if (r_count == '0) begin
                    n_st = ST_EMPTY; n_state = S_DONE;
                end else begin
                    n_ptr = (r_lo == '0) ? '0 : r_lo - 1'b1;
                    n_state = S_RD0;
                end
            end
            S_RD0: begin
                rd_addr = (r_act == ACT_INSERT) ? r_lo[AW-1:0] : r_ptr[AW-1:0];
                n_state = S_RD1;
            end
            S_RD1: begin
                if (r_act == ACT_INSERT) begin
                    if (r_lo < r_count && $signed(r_rdx) == r_x) begin
                        wr_en = 1'b1; wr_addr = r_lo[AW-1:0]; wr_x = r_x;
                        n_st = ST_UPDATED; n_state = S_DONE;
                    end else if (r_count >= CW'(MAX_POINTS)) begin
                        n_st = ST_FULL; n_state = S_DONE;
                    end else begin
                        n_ptr = r_count; n_state = S_SHIFT;
                    end
                end else if ($signed(r_rdx) == r_x) begin
                    n_res = r_rdy; n_state = S_DONE;
                end else if (r_count == CW'(1)) begin
                    n_res = r_rdy; n_state = S_DONE;
                end else if (r_ptr == r_count - 1'b1) begin
                    n_ptr = r_ptr - 1'b1; n_state = S_RD0;
                end else begin
                    n_x0 = r_rdx; n_y0 = r_rdy;
                    rd_addr = AW'(r_ptr + 1'b1);
                    n_state = S_PREP;
                end
            end
            S_SHIFT: begin
                if (r_ptr == r_lo) begin
                    wr_en = 1'b1; wr_addr = r_lo[AW-1:0];
                    n_count = r_count + 1'b1; n_state = S_DONE;
                end else begin
                    rd_addr = AW'(r_ptr - 1'b1);
                    n_state = S_SHWR;
                end
            end
            S_SHWR: begin
                wr_en = 1'b1; wr_addr = r_ptr[AW-1:0]; wr_x = r_rdx; wr_y = r_rdy;
                n_ptr = r_ptr - 1'b1; n_state = S_SHIFT;
            end
            S_PREP: begin
                // r_rdx/r_rdy now hold the upper point of the segment
                n_neg = dy_s[DW-1] ^ dq_s[DW-1];
                n_mc = PW'(dy_s[DW-1] ? DW'(-dy_s) : DW'(dy_s));
                n_acc = PW'(dq_s[DW-1] ? DW'(-dq_s) : DW'(dq_s));
                n_dx = DW'(dx_s);
                n_rem = '0; n_res = '0;
                n_cnt = CNTW'(DW);
                n_state = S_MUL;
            end
            S_MUL: begin
                // shift-add: product builds in the upper half of r_acc
                if (r_cnt == '0) begin
                    n_cnt = CNTW'(PW); n_rem = '0; n_state = S_DIV;
                end else begin
                    if (r_acc[0]) n_acc = mul_sum[PW:1];
                    else n_acc = {1'b0, r_acc[PW-1:1]};
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_DIV: begin
                // restoring divide, one quotient bit per cycle into r_acc
                if (r_cnt == '0) begin
                    n_state = S_FIN;
                end else begin
                    if (!trial[DW]) begin
                        n_rem = {1'b0, trial[DW-1:0]};
                        n_acc = {r_acc[PW-2:0], 1'b1};
                    end else begin
                        n_rem = {1'b0, r_rem[DW-2:0], r_acc[PW-1]};
                        n_acc = {r_acc[PW-2:0], 1'b0};
                    end
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_FIN: begin
                if (sum_w > VMAX) begin
                    n_res = VB'(VMAX); n_st = ST_SAT;
                end else if (sum_w < VMIN) begin
                    n_res = VB'(VMIN); n_st = ST_SAT;
                end else begin
                    n_res = VB'(sum_w);
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                n_valid = 1'b1; n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_count <= '0; r_valid <= 1'b0;
        end else begin
            r_state <= n_state; r_count <= n_count; r_valid <= n_valid;
        end
        if (r_state == S_IDLE && start) begin
            r_act <= i_action; r_x <= i_x_value; r_y <= i_y_value;
        end
        r_lo <= n_lo; r_hi <= n_hi; r_ptr <= n_ptr;
        r_x0 <= n_x0; r_y0 <= n_y0; r_acc <= n_acc; r_mc <= n_mc; r_dx <= n_dx;
        r_rem <= n_rem; r_neg <= n_neg; r_cnt <= n_cnt; r_res <= n_res; r_st <= n_st;
    end

    assign busy = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_y_result = r_res;
    assign o_status = r_st;
    assign o_point_total = 7'(r_count);

`ifndef SYNTH
    // the count only grows by one, and only at the end of an insert
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |-> (r_count == $past(r_count) + 1'b1))
        else $error("point count jumped");
    // a result strobe comes while the block is idle
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("strobe while busy");
    // the count never exceeds the table depth
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_POINTS))
        else $error("count above depth");
`endif
endmodule
